@@ design/fpri_pkg.sv @@
`timescale 1ns / 1ps

package fpri_pkg;

    // width of the shared datapath words
    localparam int unsigned WORD_W = 64;
    localparam int unsigned HALF_W = 32;

    // configuration register indexes
    localparam logic REG_ITERATIONS = 1'b0;
    localparam logic [7:0] ITER_RESET = 8'd10;

    // shared multiplier request and response
    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] p;
    } t_mul_rsp;

    // shared divider request and response
    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] num;
        logic [WORD_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] quo;
    } t_div_rsp;

endpackage

@@ design/fpri_mul.sv @@
`timescale 1ns / 1ps

module fpri_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fpri_pkg::t_mul_req i_req,
    output fpri_pkg::t_mul_rsp o_rsp
);

    logic [fpri_pkg::WORD_W-1:0] r_a;
    logic [fpri_pkg::WORD_W-1:0] r_b;
    logic [fpri_pkg::WORD_W-1:0] r_prod;
    logic [fpri_pkg::WORD_W-1:0] r_acc;
    logic [1:0]                  r_cnt;
    logic                        r_busy;
    logic                        r_done;
    logic [fpri_pkg::HALF_W-1:0] op_a;
    logic [fpri_pkg::HALF_W-1:0] op_b;

    // pick the partial product for this step, low word of the result only
    always_comb begin
        case (r_cnt)
            2'd1: begin
                op_a = r_a[fpri_pkg::HALF_W-1:0];
                op_b = r_b[fpri_pkg::WORD_W-1:fpri_pkg::HALF_W];
            end
            2'd2: begin
                op_a = r_a[fpri_pkg::WORD_W-1:fpri_pkg::HALF_W];
                op_b = r_b[fpri_pkg::HALF_W-1:0];
            end
            default: begin
                op_a = r_a[fpri_pkg::HALF_W-1:0];
                op_b = r_b[fpri_pkg::HALF_W-1:0];
            end
        endcase
    end

    // registered 32x32 product, then accumulate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_a    <= i_req.a;
                r_b    <= i_req.b;
                r_cnt  <= 2'd0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_prod <= {{fpri_pkg::HALF_W{1'b0}}, op_a} * {{fpri_pkg::HALF_W{1'b0}}, op_b};
                r_cnt  <= r_cnt + 2'd1;
                case (r_cnt)
                    2'd1: r_acc <= r_prod;
                    2'd2: r_acc <= r_acc + {r_prod[fpri_pkg::HALF_W-1:0],
                                            {fpri_pkg::HALF_W{1'b0}}};
                    2'd3: begin
                        r_acc  <= r_acc + {r_prod[fpri_pkg::HALF_W-1:0],
                                           {fpri_pkg::HALF_W{1'b0}}};
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.p    = r_acc;

endmodule

@@ design/fpri_div.sv @@
`timescale 1ns / 1ps

module fpri_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fpri_pkg::t_div_req i_req,
    output fpri_pkg::t_div_rsp o_rsp
);

    localparam int unsigned CNT_W = $clog2(fpri_pkg::WORD_W);

    logic [fpri_pkg::WORD_W-1:0] r_rem;
    logic [fpri_pkg::WORD_W-1:0] r_quo;
    logic [fpri_pkg::WORD_W-1:0] r_den;
    logic [CNT_W-1:0]            r_cnt;
    logic                        r_busy;
    logic                        r_done;
    logic [fpri_pkg::WORD_W:0]   trial;
    logic [fpri_pkg::WORD_W:0]   diff;
    logic                        ge;
    logic [fpri_pkg::WORD_W-1:0] n_rem;

    // one restoring step: shift in a dividend bit, subtract when it fits
    always_comb begin
        trial = {r_rem, r_quo[fpri_pkg::WORD_W-1]};
        diff  = trial - {1'b0, r_den};
        ge    = (trial >= {1'b0, r_den});
        n_rem = ge ? diff[fpri_pkg::WORD_W-1:0] : trial[fpri_pkg::WORD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_rem  <= '0;
                r_quo  <= i_req.num;
                r_den  <= i_req.den;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= {r_quo[fpri_pkg::WORD_W-2:0], ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(fpri_pkg::WORD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

@@ design/fixed_point_rotation_iteration_top.sv @@
`timescale 1ns / 1ps

// fixed-point rotation refinement of a 3x3 cross-covariance matrix
// input channel: one signed entry per request, row-major, nine per matrix;
//   o_entry_ready is high only while a matrix is being loaded
// output channel: nine Q(FRACTION_BITS) results per matrix, row-major, each
//   saturated to 32 bits; o_last marks the ninth, o_degenerate an all-zero matrix
// after the ninth entry: normalization runs one 64-step divide per entry, then
//   each of the iterations passes does nine squares, one 64-step divide for k
//   and three multiplies per entry before the results follow; an all-zero
//   matrix skips straight to output
// one 64-bit divider (one bit a cycle) and one 32x32 multiplier (three partial
//   products per 64-bit product) are shared by every step
// results leave one at a time; a stalled receiver holds the result
//   and the block waits, no new entry is taken until all nine are delivered
// reset (synchronous, active low) returns to loading an empty matrix and sets
//   iterations to 10; the apb port takes writes at any time the block is idle
module fixed_point_rotation_iteration_top #(
    parameter int FRACTION_BITS = 20,
    parameter int ENTRY_WIDTH   = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // entry channel
    input  logic                   i_entry_valid,
    output logic                   o_entry_ready,
    input  logic [ENTRY_WIDTH-1:0] i_entry,
    // result channel
    output logic                   o_result_valid,
    input  logic                   i_result_ready,
    output logic [31:0]            o_value,
    output logic                   o_last,
    output logic                   o_degenerate,
    // configuration port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [2:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam int W = fpri_pkg::WORD_W;
    localparam logic [W-1:0] K_NUM  = W'(1) << (3 * FRACTION_BITS + 2);
    localparam logic [W-1:0] TWO_F  = W'(2) << FRACTION_BITS;
    localparam logic [W-1:0] SAT_HI = 64'h0000_0000_7FFF_FFFF;
    localparam logic [W-1:0] SAT_LO = 64'hFFFF_FFFF_8000_0000;

    typedef enum logic [4:0] {
        S_LOAD, S_NRM_RD, S_NRM_DIV, S_NRM_WAIT, S_PASS,
        S_SQ_RD, S_SQ_MUL, S_SQ_WAIT, S_K_DIV, S_K_WAIT,
        S_E_RD1, S_E_M1, S_E_W1, S_E_RD2, S_E_M2, S_E_W2, S_E_M3, S_E_W3,
        S_OUT_RD, S_OUT_SET, S_OUT_WAIT
    } t_state;

    t_state               r_state;
    logic [3:0]           r_cnt;
    logic [3:0]           r_idx;
    logic [31:0]          r_max;
    logic [7:0]           r_iter;
    logic [7:0]           r_itc;
    logic                 r_bank;
    logic                 r_degen;
    logic                 r_neg;
    logic [W-1:0]         r_s;
    logic [W-1:0]         r_k;
    logic [W-1:0]         r_m1;
    logic [W-1:0]         r_t;
    logic [W-1:0]         r_rd0;
    logic [W-1:0]         r_rd1;
    logic                 r_valid;
    logic [31:0]          r_value;
    logic                 r_last;

    logic [W-1:0]         mem [18];
    logic [4:0]           ra0;
    logic [4:0]           ra1;
    logic                 we;
    logic [4:0]           wa;
    logic [W-1:0]         wd;

    fpri_pkg::t_mul_req   mul_req;
    fpri_pkg::t_mul_rsp   mul_rsp;
    fpri_pkg::t_div_req   div_req;
    fpri_pkg::t_div_rsp   div_rsp;

    logic [W-1:0]         e64;
    logic [W-1:0]         e_abs;
    logic [31:0]          e_mag;
    logic [31:0]          n_max;
    logic [W-1:0]         v_abs;
    logic [W-1:0]         d_val;
    logic [W-1:0]         d_abs;
    logic [W-1:0]         n_t;
    logic [W-1:0]         sat_v;
    logic                 cfg_wr;
    logic [1:0]           row;
    logic [1:0]           col;
    logic [1:0]           ur;
    logic [1:0]           vr;
    logic [1:0]           ca;
    logic [1:0]           cb;

    function automatic logic [1:0] f_next3(input logic [1:0] x);
        f_next3 = (x == 2'd2) ? 2'd0 : x + 2'd1;
    endfunction

    function automatic logic [3:0] f_pos(input logic [1:0] rw, input logic [1:0] cl);
        f_pos = {1'b0, rw, 1'b0} + {2'b00, rw} + {2'b00, cl};
    endfunction

    function automatic logic [4:0] f_addr(input logic bank, input logic [3:0] i);
        f_addr = {1'b0, i} + (bank ? 5'd9 : 5'd0);
    endfunction

    // row and column of the current entry, and the two other rows and columns it crosses
    always_comb begin
        case (r_idx)
            4'd0, 4'd1, 4'd2: row = 2'd0;
            4'd3, 4'd4, 4'd5: row = 2'd1;
            default:          row = 2'd2;
        endcase
        case (r_idx)
            4'd0, 4'd3, 4'd6: col = 2'd0;
            4'd1, 4'd4, 4'd7: col = 2'd1;
            default:          col = 2'd2;
        endcase
        ur = f_next3(row);
        vr = f_next3(ur);
        ca = f_next3(col);
        cb = f_next3(ca);
    end

    // entry sign extension and magnitude, running maximum, divide operands, update term and output saturation
    always_comb begin
        e64   = {{(W - ENTRY_WIDTH){i_entry[ENTRY_WIDTH-1]}}, i_entry};
        e_abs = e64[W-1] ? (W'(0) - e64) : e64;
        e_mag = e_abs[31:0];
        n_max = (e_mag > r_max) ? e_mag : r_max;
        v_abs = r_rd0[W-1] ? (W'(0) - r_rd0) : r_rd0;
        d_val = W'($signed(r_s) >>> FRACTION_BITS) + TWO_F;
        d_abs = d_val[W-1] ? (W'(0) - d_val) : d_val;
        n_t   = W'($signed(r_m1 - mul_rsp.p) >>> FRACTION_BITS) + r_rd0;
        if (r_rd0[W-1] && (r_rd0 < SAT_LO)) begin
            sat_v = SAT_LO;
        end else if (!r_rd0[W-1] && (r_rd0 > SAT_HI)) begin
            sat_v = SAT_HI;
        end else begin
            sat_v = r_rd0;
        end
    end

    // memory ports and shared unit requests
    always_comb begin
        ra0 = f_addr(r_bank, r_idx);
        ra1 = f_addr(r_bank, r_idx);
        we  = 1'b0;
        wa  = f_addr(r_bank, r_idx);
        wd  = W'($signed(mul_rsp.p) >>> (2 * FRACTION_BITS));
        mul_req.start = 1'b0;
        mul_req.a     = r_rd0;
        mul_req.b     = r_rd1;
        div_req.start = 1'b0;
        div_req.num   = v_abs << FRACTION_BITS;
        div_req.den   = {32'd0, r_max};
        case (r_state)
            S_LOAD: begin
                we = i_entry_valid;
                wa = f_addr(1'b0, r_cnt);
                wd = e64;
            end
            S_NRM_DIV: div_req.start = 1'b1;
            S_NRM_WAIT: begin
                we = div_rsp.done;
                wd = r_neg ? (W'(0) - div_rsp.quo) : div_rsp.quo;
            end
            S_SQ_MUL: begin
                mul_req.start = 1'b1;
                mul_req.b     = r_rd0;
            end
            S_K_DIV: begin
                div_req.start = (d_val != W'(0));
                div_req.num   = K_NUM;
                div_req.den   = d_abs;
            end
            S_E_RD1: begin
                ra0 = f_addr(r_bank, f_pos(ur, ca));
                ra1 = f_addr(r_bank, f_pos(vr, cb));
            end
            S_E_M1: mul_req.start = 1'b1;
            S_E_RD2: begin
                ra0 = f_addr(r_bank, f_pos(ur, cb));
                ra1 = f_addr(r_bank, f_pos(vr, ca));
            end
            S_E_M2: mul_req.start = 1'b1;
            S_E_M3: begin
                mul_req.start = 1'b1;
                mul_req.a     = r_k;
                mul_req.b     = r_t;
            end
            S_E_W3: begin
                we = mul_rsp.done;
                wa = f_addr(~r_bank, r_idx);
            end
            default: ;
        endcase
    end

    // matrix storage, two banks swapped every pass
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        r_rd0 <= mem[ra0];
        r_rd1 <= mem[ra1];
    end

    fpri_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    fpri_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // configuration register
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == fpri_pkg::REG_ITERATIONS) ? {24'd0, r_iter} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iter <= fpri_pkg::ITER_RESET;
        end else if (cfg_wr && (paddr[2] == fpri_pkg::REG_ITERATIONS)) begin
            r_iter <= pwdata[7:0];
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt   <= 4'd0;
            r_idx   <= 4'd0;
            r_max   <= 32'd0;
            r_bank  <= 1'b0;
            r_degen <= 1'b0;
            r_valid <= 1'b0;
            r_itc   <= 8'd0;
        end else begin
            case (r_state)
                S_LOAD: begin
                    if (i_entry_valid) begin
                        r_max <= n_max;
                        r_idx <= 4'd0;
                        r_bank <= 1'b0;
                        if (r_cnt == 4'd8) begin
                            r_cnt   <= 4'd0;
                            r_itc   <= r_iter;
                            r_degen <= (n_max == 32'd0);
                            r_state <= (n_max == 32'd0) ? S_OUT_RD : S_NRM_RD;
                        end else begin
                            r_cnt <= r_cnt + 4'd1;
                        end
                    end
                end
                S_NRM_RD: r_state <= S_NRM_DIV;
                S_NRM_DIV: begin
                    r_neg   <= r_rd0[W-1];
                    r_state <= S_NRM_WAIT;
                end
                S_NRM_WAIT: begin
                    if (div_rsp.done) begin
                        r_idx   <= r_idx + 4'd1;
                        r_state <= (r_idx == 4'd8) ? S_PASS : S_NRM_RD;
                    end
                end
                S_PASS: begin
                    r_idx <= 4'd0;
                    r_s   <= '0;
                    if (r_itc == 8'd0) begin
                        r_state <= S_OUT_RD;
                    end else begin
                        r_itc   <= r_itc - 8'd1;
                        r_state <= S_SQ_RD;
                    end
                end
                S_SQ_RD:  r_state <= S_SQ_MUL;
                S_SQ_MUL: r_state <= S_SQ_WAIT;
                S_SQ_WAIT: begin
                    if (mul_rsp.done) begin
                        r_s <= r_s + mul_rsp.p;
                        if (r_idx == 4'd8) begin
                            r_idx   <= 4'd0;
                            r_state <= S_K_DIV;
                        end else begin
                            r_idx   <= r_idx + 4'd1;
                            r_state <= S_SQ_RD;
                        end
                    end
                end
                S_K_DIV: begin
                    r_neg <= d_val[W-1];
                    if (d_val == W'(0)) begin
                        r_k     <= '0;
                        r_state <= S_E_RD1;
                    end else begin
                        r_state <= S_K_WAIT;
                    end
                end
                S_K_WAIT: begin
                    if (div_rsp.done) begin
                        r_k     <= r_neg ? (W'(0) - div_rsp.quo) : div_rsp.quo;
                        r_state <= S_E_RD1;
                    end
                end
                S_E_RD1: r_state <= S_E_M1;
                S_E_M1:  r_state <= S_E_W1;
                S_E_W1: begin
                    if (mul_rsp.done) begin
                        r_m1    <= mul_rsp.p;
                        r_state <= S_E_RD2;
                    end
                end
                S_E_RD2: r_state <= S_E_M2;
                S_E_M2:  r_state <= S_E_W2;
                S_E_W2: begin
                    if (mul_rsp.done) begin
                        r_t     <= n_t;
                        r_state <= S_E_M3;
                    end
                end
                S_E_M3: r_state <= S_E_W3;
                S_E_W3: begin
                    if (mul_rsp.done) begin
                        if (r_idx == 4'd8) begin
                            r_bank  <= ~r_bank;
                            r_state <= S_PASS;
                        end else begin
                            r_idx   <= r_idx + 4'd1;
                            r_state <= S_E_RD1;
                        end
                    end
                end
                S_OUT_RD: r_state <= S_OUT_SET;
                S_OUT_SET: begin
                    r_valid <= 1'b1;
                    r_value <= r_degen ? 32'd0 : sat_v[31:0];
                    r_last  <= (r_idx == 4'd8);
                    r_state <= S_OUT_WAIT;
                end
                S_OUT_WAIT: begin
                    if (i_result_ready) begin
                        r_valid <= 1'b0;
                        if (r_last) begin
                            r_idx   <= 4'd0;
                            r_max   <= 32'd0;
                            r_state <= S_LOAD;
                        end else begin
                            r_idx   <= r_idx + 4'd1;
                            r_state <= S_OUT_RD;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign o_entry_ready  = (r_state == S_LOAD);
    assign o_result_valid = r_valid;
    assign o_value        = r_value;
    assign o_last         = r_last;
    assign o_degenerate   = r_degen;

`ifndef SYNTH
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_entry_ready |-> !o_result_valid)
        else $error("entry taken while a result is pending");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_degenerate) |-> (o_value == 32'd0))
        else $error("degenerate result is not zero");

    a_units_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mul_rsp.done && div_rsp.done))
        else $error("multiplier and divider finished together");

    a_last_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && i_result_ready && o_last) |=> o_entry_ready)
        else $error("no return to loading after the last result");
`endif

endmodule
